/* src/arc_pkg.sv */
// Shared types, sizes and codes for the address-resolution cache.
package arc_pkg;

	// Table geometry
	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// Field widths
	localparam int KIND_W = 2;
	localparam int KEY_W = 8;
	localparam int MAC_W = 48;
	localparam int IFACE_W = 8;
	localparam int STAT_W = 2;
	localparam int COUNT_OUT_W = 5;
	localparam int REC_W = KEY_W + MAC_W + IFACE_W;

	// Operation codes
	localparam logic [KIND_W-1:0] OP_ADD = 2'd0;
	localparam logic [KIND_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] OP_DELETE = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [MAC_W-1:0] mac;
		logic [IFACE_W-1:0] iface;
	} rec_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [MAC_W-1:0] mac;
		logic [IFACE_W-1:0] iface;
		logic [COUNT_OUT_W-1:0] count;
	} res_t;

	// Fit the record count into the result field, keeping the low bits
	function automatic logic [COUNT_OUT_W-1:0] to_count_out(input logic [CNT_W-1:0] c);
		logic [CNT_W+COUNT_OUT_W-1:0] wide;
		wide = {{COUNT_OUT_W{1'b0}}, c};
		return wide[COUNT_OUT_W-1:0];
	endfunction

endpackage

/* src/arc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module arc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* src/arc_engine.sv */
// Operation sequencer: add, linear scan for lookup and delete, move-last on delete.
module arc_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [arc_pkg::KIND_W-1:0]     kind,
	input  logic [arc_pkg::KEY_W-1:0]      node_address,
	input  logic [arc_pkg::MAC_W-1:0]      mac_in,
	input  logic [arc_pkg::IFACE_W-1:0]    iface_in,
	output logic                           res_valid,
	output arc_pkg::res_t                  res,
	input  logic                           res_free,
	output logic                           wr_en,
	output logic [arc_pkg::IDX_W-1:0]      wr_addr,
	output logic [arc_pkg::REC_W-1:0]      wr_data,
	output logic                           rd_en,
	output logic [arc_pkg::IDX_W-1:0]      rd_addr,
	input  logic [arc_pkg::REC_W-1:0]      rd_data
);
	import arc_pkg::*;

	state_t state_q, state_next;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] last;
	logic chk_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] pos_q;
	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0] key_q;
	logic [STAT_W-1:0] status_q;
	logic [MAC_W-1:0] mac_q;
	logic [IFACE_W-1:0] iface_q;
	rec_t rd_rec;
	rec_t in_rec;
	logic issue;
	logic hit;
	logic scan_miss;
	logic room;
	logic is_scan_op;

	assign rd_rec = rd_data;
	assign in_rec = '{key: node_address, mac: mac_in, iface: iface_in};
	assign room = count_q < CNT_W'(ENTRIES);
	assign last = count_q - CNT_W'(1);
	assign is_scan_op = (kind == OP_LOOKUP) || (kind == OP_DELETE);

	// Scan pipeline: read slot idx_q, compare slot idx_s1 in the cycle after
	assign issue = idx_q < count_q;
	assign hit = chk_s1 && (rd_rec.key == key_q);
	assign scan_miss = !hit && !issue && !chk_s1;

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = is_scan_op ? ST_SCAN : ST_FIN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_next = (kind_q == OP_DELETE) ? ST_DEL_RD : ST_FIN;
				end else if (scan_miss) begin
					state_next = ST_FIN;
				end
			end
			ST_DEL_RD: state_next = ST_DEL_WR;
			ST_DEL_WR: state_next = ST_FIN;
			ST_FIN: begin
				if (res_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Outputs and memory controls
	always_comb begin
		in_stall = 1'b1;
		res_valid = 1'b0;
		wr_en = 1'b0;
		wr_addr = pos_q;
		wr_data = rd_data;
		rd_en = 1'b0;
		rd_addr = idx_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				wr_en = in_valid && (kind == OP_ADD) && room;
				wr_addr = count_q[IDX_W-1:0];
				wr_data = in_rec;
			end
			ST_SCAN: begin
				rd_en = issue;
			end
			ST_DEL_RD: begin
				rd_en = 1'b1;
				rd_addr = last[IDX_W-1:0];
			end
			ST_DEL_WR: begin
				wr_en = 1'b1;
			end
			ST_FIN: begin
				res_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign res = '{status: status_q, mac: mac_q, iface: iface_q, count: to_count_out(count_q)};

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Count and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			chk_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q <= '0;
						chk_s1 <= 1'b0;
						if ((kind == OP_ADD) && room) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (!hit && !scan_miss) begin
						idx_q <= idx_q + CNT_W'(issue);
						chk_s1 <= issue;
					end
				end
				ST_DEL_WR: begin
					count_q <= last;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					kind_q <= kind;
					key_q <= node_address;
					mac_q <= '0;
					iface_q <= '0;
					status_q <= ((kind == OP_ADD) && !room) ? STAT_FULL : STAT_OK;
				end
			end
			ST_SCAN: begin
				idx_s1 <= idx_q[IDX_W-1:0];
				if (hit) begin
					pos_q <= idx_s1;
					status_q <= STAT_OK;
					if (kind_q == OP_LOOKUP) begin
						mac_q <= rd_rec.mac;
						iface_q <= rd_rec.iface;
					end
				end else if (scan_miss) begin
					status_q <= STAT_MISSING;
				end
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

endmodule

/* src/address_resolution_cache_core.sv */
// Address-resolution cache top level: record memory, sequencer and output register.
//
// Holds up to ENTRIES records (key, MAC, interface) in one RAM with a registered
// read. One item is processed at a time. An add or an unused kind goes from
// acceptance to the finish state and from there into the output register. Lookup
// and delete walk the records from slot 0 through the RAM read port at one record
// per cycle, and a delete then reads the last record and writes it into the freed
// slot. The next item is accepted once the result has moved into the output
// register, even if that beat is still stalled.
module address_resolution_cache_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [arc_pkg::KIND_W-1:0]     kind,
	input  logic [arc_pkg::KEY_W-1:0]      node_address,
	input  logic [arc_pkg::MAC_W-1:0]      mac_in,
	input  logic [arc_pkg::IFACE_W-1:0]    iface_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [arc_pkg::STAT_W-1:0]     status,
	output logic [arc_pkg::MAC_W-1:0]      mac_out,
	output logic [arc_pkg::IFACE_W-1:0]    iface_out,
	output logic [arc_pkg::COUNT_OUT_W-1:0] count_out
);
	import arc_pkg::*;

	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [REC_W-1:0] wr_data;
	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [REC_W-1:0] rd_data;
	logic res_valid;
	logic res_free;
	res_t res;
	logic out_valid_q;
	res_t out_q;

	arc_ram #(
		.WIDTH(REC_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	arc_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.node_address(node_address),
		.mac_in(mac_in),
		.iface_in(iface_in),
		.res_valid(res_valid),
		.res(res),
		.res_free(res_free),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Output register: load when empty or draining this cycle
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result beat while stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_free) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign mac_out = out_q.mac;
	assign iface_out = out_q.iface;
	assign count_out = out_q.count;

endmodule
